// ----- rtl/atcmd_pkg.sv -----
// atcmd_pkg: shared constants, types and helper functions of the AT command line recognizer
// no dependencies; used by every module in rtl/ except atcmd_ram
`default_nettype none

package atcmd_pkg;

  localparam int unsigned LINE_CAP   = 256;
  localparam int unsigned FIELD_CAP  = 64;
  localparam int unsigned PREFIX_LEN = 12;
  localparam int unsigned ADDR_W     = $clog2(LINE_CAP);
  localparam int unsigned LEN_W      = $clog2(LINE_CAP);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic {
    OP_RX   = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    CMD_EMPTY     = 4'd0,
    CMD_AT        = 4'd1,
    CMD_USAGE     = 4'd2,
    CMD_FORECAST  = 4'd3,
    CMD_THERMAL   = 4'd4,
    CMD_LUX       = 4'd5,
    CMD_BAT       = 4'd6,
    CMD_RST       = 4'd7,
    CMD_WIFI_OK   = 4'd8,
    CMD_WIFI_NARG = 4'd9,
    CMD_WIFI_NCOM = 4'd10,
    CMD_UNKNOWN   = 4'd11
  } cmd_code_e;

  typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;
  typedef logic [8*PREFIX_LEN-1:0] pattern_t;

  // patterns are left aligned: character 0 in the top byte
  localparam pattern_t PAT_AT       = {"AT", {10{8'h00}}};
  localparam pattern_t PAT_HELP     = {"AT+HELP", {5{8'h00}}};
  localparam pattern_t PAT_HELPQ    = {"AT+HELP?", {4{8'h00}}};
  localparam pattern_t PAT_WEATHER  = {"AT+WEATHER?", 8'h00};
  localparam pattern_t PAT_TEMP     = {"AT+TEMP?", {4{8'h00}}};
  localparam pattern_t PAT_LUX      = {"AT+LUX?", {5{8'h00}}};
  localparam pattern_t PAT_BAT      = {"AT+BAT?", {5{8'h00}}};
  localparam pattern_t PAT_RST      = {"AT+RST", {6{8'h00}}};
  localparam pattern_t PAT_WIFI     = {"AT+WIFI=", {4{8'h00}}};

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             zero_vld;
    logic [LEN_W-1:0] zero_pos;
    logic             comma_vld;
    logic [LEN_W-1:0] comma_pos;
  } line_state_t;

  typedef struct packed {
    cmd_code_e   code;
    logic [7:0]  comma;
    logic [5:0]  name_len;
    logic [5:0]  pwd_len;
  } cls_t;

  // first n stored characters equal the first n pattern characters
  function automatic logic pfx_match(prefix_t pre, pattern_t pat, int unsigned n);
    logic m;
    m = 1'b1;
    for (int unsigned i = 0; i < PREFIX_LEN; i++) begin
      if (i < n && pre[i] != pat[8*(PREFIX_LEN-i)-1 -: 8]) begin
        m = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [5:0] clip_field(logic [LEN_W-1:0] v);
    logic [5:0] r;
    if (32'(v) > 32'(FIELD_CAP - 1)) begin
      r = 6'(FIELD_CAP - 1);
    end else begin
      r = 6'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/atcmd_ram.sv -----
// atcmd_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module atcmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/atcmd_line_track.sv -----
// atcmd_line_track: line length, first comma, first zero byte and prefix copy,
// updated as console bytes arrive; depends on atcmd_pkg
`default_nettype none

module atcmd_line_track (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   upd_i,
  input  wire logic [7:0]             rx_byte_i,
  output atcmd_pkg::line_state_t      st_o,
  output atcmd_pkg::prefix_t          prefix_o,
  output logic                        wr_en_o,
  output logic [atcmd_pkg::ADDR_W-1:0] wr_addr_o
);

  atcmd_pkg::line_state_t st_q, st_d;
  atcmd_pkg::prefix_t     prefix_q, prefix_d;
  logic                   is_eol, is_bs, can_store;
  logic [atcmd_pkg::LEN_W-1:0] len_m1;

  assign is_eol    = (rx_byte_i == atcmd_pkg::CH_CR) || (rx_byte_i == atcmd_pkg::CH_LF);
  assign is_bs     = (rx_byte_i == atcmd_pkg::CH_BS) || (rx_byte_i == atcmd_pkg::CH_DEL);
  assign can_store = st_q.len < atcmd_pkg::LEN_W'(atcmd_pkg::LINE_CAP - 2);
  assign len_m1    = st_q.len - atcmd_pkg::LEN_W'(1);

  always_comb begin
    st_d     = st_q;
    prefix_d = prefix_q;
    wr_en_o  = 1'b0;
    if (upd_i) begin
      priority if (is_eol) begin
        if (st_q.len != '0) begin
          st_d.len       = '0;
          st_d.zero_vld  = 1'b0;
          st_d.comma_vld = 1'b0;
        end
      end else if (is_bs) begin
        if (st_q.len != '0) begin
          st_d.len = len_m1;
          if (st_q.zero_vld && st_q.zero_pos == len_m1) begin
            st_d.zero_vld = 1'b0;
          end
          if (st_q.comma_vld && st_q.comma_pos == len_m1) begin
            st_d.comma_vld = 1'b0;
          end
        end
      end else if (can_store) begin
        wr_en_o  = 1'b1;
        st_d.len = st_q.len + atcmd_pkg::LEN_W'(1);
        for (int unsigned i = 0; i < atcmd_pkg::PREFIX_LEN; i++) begin
          if (32'(st_q.len) == i) begin
            prefix_d[i] = rx_byte_i;
          end
        end
        if (rx_byte_i == atcmd_pkg::CH_NUL && !st_q.zero_vld) begin
          st_d.zero_vld = 1'b1;
          st_d.zero_pos = st_q.len;
        end
        if (rx_byte_i == atcmd_pkg::CH_COMMA && !st_q.comma_vld) begin
          st_d.comma_vld = 1'b1;
          st_d.comma_pos = st_q.len;
        end
      end else begin
        st_d = st_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      prefix_q <= '0;
    end else begin
      st_q     <= st_d;
      prefix_q <= prefix_d;
    end
  end

  assign st_o      = st_q;
  assign prefix_o  = prefix_q;
  assign wr_addr_o = atcmd_pkg::ADDR_W'(st_q.len);

endmodule

`default_nettype wire

// ----- rtl/atcmd_classify.sv -----
// atcmd_classify: decodes the finished line into a command code and wifi field lengths
// depends on atcmd_pkg
`default_nettype none

module atcmd_classify (
  input  wire atcmd_pkg::line_state_t st_i,
  input  wire atcmd_pkg::prefix_t     prefix_i,
  output atcmd_pkg::cls_t             cls_o
);

  logic [atcmd_pkg::LEN_W-1:0] eff;

  assign eff = st_i.zero_vld ? st_i.zero_pos : st_i.len;

  function automatic logic is_exact(atcmd_pkg::prefix_t pre, logic [atcmd_pkg::LEN_W-1:0] e,
                                    atcmd_pkg::pattern_t pat, int unsigned n);
    return (32'(e) == n) && atcmd_pkg::pfx_match(pre, pat, n);
  endfunction

  always_comb begin
    cls_o = '{code: atcmd_pkg::CMD_UNKNOWN, comma: '0, name_len: '0, pwd_len: '0};
    priority if (eff == '0) begin
      cls_o.code = atcmd_pkg::CMD_EMPTY;
    end else if (is_exact(prefix_i, eff, atcmd_pkg::PAT_AT, 2)) begin
      cls_o.code = atcmd_pkg::CMD_AT;
    end else if (is_exact(prefix_i, eff, atcmd_pkg::PAT_HELP, 7) ||
                 is_exact(prefix_i, eff, atcmd_pkg::PAT_HELPQ, 8)) begin
      cls_o.code = atcmd_pkg::CMD_USAGE;
    end else if (is_exact(prefix_i, eff, atcmd_pkg::PAT_WEATHER, 11)) begin
      cls_o.code = atcmd_pkg::CMD_FORECAST;
    end else if (is_exact(prefix_i, eff, atcmd_pkg::PAT_TEMP, 8)) begin
      cls_o.code = atcmd_pkg::CMD_THERMAL;
    end else if (is_exact(prefix_i, eff, atcmd_pkg::PAT_LUX, 7)) begin
      cls_o.code = atcmd_pkg::CMD_LUX;
    end else if (is_exact(prefix_i, eff, atcmd_pkg::PAT_BAT, 7)) begin
      cls_o.code = atcmd_pkg::CMD_BAT;
    end else if (is_exact(prefix_i, eff, atcmd_pkg::PAT_RST, 6)) begin
      cls_o.code = atcmd_pkg::CMD_RST;
    end else if ((32'(eff) >= 32'd8) && atcmd_pkg::pfx_match(prefix_i, atcmd_pkg::PAT_WIFI, 8)) begin
      priority if (32'(eff) == 32'd8) begin
        cls_o.code = atcmd_pkg::CMD_WIFI_NARG;
      end else if (!st_i.comma_vld || st_i.comma_pos >= eff) begin
        cls_o.code = atcmd_pkg::CMD_WIFI_NCOM;
      end else begin
        cls_o.code     = atcmd_pkg::CMD_WIFI_OK;
        cls_o.comma    = 8'(st_i.comma_pos);
        cls_o.name_len = atcmd_pkg::clip_field(st_i.comma_pos - atcmd_pkg::LEN_W'(8));
        cls_o.pwd_len  = atcmd_pkg::clip_field(eff - st_i.comma_pos - atcmd_pkg::LEN_W'(1));
      end
    end else begin
      cls_o.code = atcmd_pkg::CMD_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/at_command_line_recognizer_core.sv -----
// at_command_line_recognizer_core: top level, input handshake, line store, output register
// depends on atcmd_pkg, atcmd_ram, atcmd_line_track, atcmd_classify
`default_nettype none

//   channel | handshake                | payload
//   --------+--------------------------+--------------------------------------------
//   in      | in_valid_i / in_stall_o  | command_i, rx_byte_i, read_index_i
//   out     | out_valid_o / out_stall_i| echo_valid_o, echo_byte_o, line_done_o,
//           |                          | cmd_code_o, comma_index_o, name_len_o,
//           |                          | pwd_len_o, read_data_o
//
// one request per cycle unless stalled; results appear in the cycle after the request is taken
// a store read goes through the ram's registered read port, aligned with the result register
// reset clears line length, comma and zero tracking and the prefix copy; the store is not cleared
// in_stall_o is high only while a result is held and out_stall_i is high

module at_command_line_recognizer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       command_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [7:0] read_index_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            echo_valid_o,
  output logic [7:0]      echo_byte_o,
  output logic            line_done_o,
  output logic [3:0]      cmd_code_o,
  output logic [7:0]      comma_index_o,
  output logic [5:0]      name_len_o,
  output logic [5:0]      pwd_len_o,
  output logic [7:0]      read_data_o
);

  logic accept, is_rx, is_rd, is_eol, done;
  logic out_valid_q, out_valid_d;
  logic wr_en;
  logic [atcmd_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic idx_ok;
  logic [7:0] ram_rdata;
  atcmd_pkg::line_state_t st;
  atcmd_pkg::prefix_t     prefix;
  atcmd_pkg::cls_t        cls;

  logic       echo_valid_q, echo_valid_d;
  logic [7:0] echo_byte_q, echo_byte_d;
  logic       line_done_q, line_done_d;
  logic [3:0] cmd_code_q, cmd_code_d;
  logic [7:0] comma_q, comma_d;
  logic [5:0] ssid_q, ssid_d;
  logic [5:0] pwd_q, pwd_d;
  logic       rd_ok_q, rd_ok_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_rd      = (command_i == atcmd_pkg::OP_READ);
  assign is_rx      = accept & ~is_rd;
  assign is_eol     = (rx_byte_i == atcmd_pkg::CH_CR) || (rx_byte_i == atcmd_pkg::CH_LF);
  assign done       = is_eol && (st.len != '0);

  assign idx_ok  = 32'(read_index_i) < 32'(atcmd_pkg::LINE_CAP);
  assign rd_addr = atcmd_pkg::ADDR_W'(read_index_i);

  atcmd_line_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (is_rx),
    .rx_byte_i (rx_byte_i),
    .st_o      (st),
    .prefix_o  (prefix),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr)
  );

  atcmd_classify u_cls (
    .st_i     (st),
    .prefix_i (prefix),
    .cls_o    (cls)
  );

  atcmd_ram #(
    .WIDTH (8),
    .DEPTH (atcmd_pkg::LINE_CAP)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (rx_byte_i),
    .re_i    (accept & is_rd),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    echo_valid_d = 1'b0;
    echo_byte_d  = '0;
    line_done_d  = 1'b0;
    cmd_code_d   = atcmd_pkg::CMD_EMPTY;
    comma_d      = '0;
    ssid_d       = '0;
    pwd_d        = '0;
    rd_ok_d      = 1'b0;
    if (is_rd) begin
      rd_ok_d = idx_ok;
    end else begin
      echo_valid_d = 1'b1;
      echo_byte_d  = rx_byte_i;
      if (done) begin
        line_done_d = 1'b1;
        cmd_code_d  = cls.code;
        comma_d     = cls.comma;
        ssid_d      = cls.name_len;
        pwd_d       = cls.pwd_len;
      end
    end
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      echo_valid_q <= echo_valid_d;
      echo_byte_q  <= echo_byte_d;
      line_done_q  <= line_done_d;
      cmd_code_q   <= cmd_code_d;
      comma_q      <= comma_d;
      ssid_q       <= ssid_d;
      pwd_q        <= pwd_d;
      rd_ok_q      <= rd_ok_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign echo_valid_o  = echo_valid_q;
  assign echo_byte_o   = echo_byte_q;
  assign line_done_o   = line_done_q;
  assign cmd_code_o    = cmd_code_q;
  assign comma_index_o = comma_q;
  assign name_len_o    = ssid_q;
  assign pwd_len_o     = pwd_q;
  assign read_data_o   = rd_ok_q ? ram_rdata : 8'h00;

endmodule

`default_nettype wire

// ----- tb/at_command_line_recognizer_core_test.sv -----
// self-checking testbench for at_command_line_recognizer_core: directed table, then random lines
// uses atcmd_pkg for codes and sizes; own line tracker predicts all results not set by the table
module at_command_line_recognizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 412;

  typedef struct packed {
    logic                 echo_valid;
    logic [7:0]           echo_byte;
    logic                 line_done;
    atcmd_pkg::cmd_code_e cmd_code;
    logic [7:0]           comma_index;
    logic [5:0]           name_len;
    logic [5:0]           pwd_len;
    logic [7:0]           read_data;
  } line_result_t;

  typedef struct {
    atcmd_pkg::op_e op;
    logic [7:0]     rx;
    logic [7:0]     ix;
    bit             typed;
    line_result_t   res;
  } dir_row_t;

  typedef enum int {
    SEQ_KNOWN,
    SEQ_WIFI,
    SEQ_READS,
    SEQ_NOISE,
    SEQ_JUNK,
    SEQ_LONG
  } seq_kind_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       command_i = atcmd_pkg::OP_RX;
  logic [7:0] rx_byte_i = 8'h00;
  logic [7:0] read_index_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       echo_valid_o;
  logic [7:0] echo_byte_o;
  logic       line_done_o;
  logic [3:0] cmd_code_o;
  logic [7:0] comma_index_o;
  logic [5:0] name_len_o;
  logic [5:0] pwd_len_o;
  logic [7:0] read_data_o;

  at_command_line_recognizer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .rx_byte_i     (rx_byte_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .echo_valid_o  (echo_valid_o),
    .echo_byte_o   (echo_byte_o),
    .line_done_o   (line_done_o),
    .cmd_code_o    (cmd_code_o),
    .comma_index_o (comma_index_o),
    .name_len_o    (name_len_o),
    .pwd_len_o     (pwd_len_o),
    .read_data_o   (read_data_o)
  );

  // line tracker state
  logic [7:0] line_mem [atcmd_pkg::LINE_CAP];
  bit         line_mem_set [atcmd_pkg::LINE_CAP];
  logic [7:0] head_chars [atcmd_pkg::PREFIX_LEN] = '{default: 8'h00};
  int         line_len = 0;
  int         comma_at = -1;
  int         zero_at = -1;

  line_result_t pending_results [$];
  bit           gold_on = 1'b0;
  line_result_t gold_res = '0;
  int           fail_count = 0;
  int           results_seen = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           hold_asks = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  dir_row_t     dir_tab [$];

  string known_cmds [8] = '{"AT", "AT+HELP", "AT+HELP?", "AT+WEATHER?", "AT+TEMP?",
                            "AT+LUX?", "AT+BAT?", "AT+RST"};
  int    tx_pct_by_phase [4] = '{0, 48, 0, 13};
  int    rx_pct_by_phase [4] = '{0, 0, 48, 13};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit head_is(string pat, int eff, bit exact);
    int n;
    n = pat.len();
    if (n > atcmd_pkg::PREFIX_LEN) return 1'b0;
    if (exact ? (eff != n) : (eff < n)) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (head_chars[i] != pat[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [5:0] clip_len(int v);
    return (v > atcmd_pkg::FIELD_CAP - 1) ? 6'(atcmd_pkg::FIELD_CAP - 1) : 6'(v);
  endfunction

  function automatic line_result_t recognize(atcmd_pkg::op_e op, logic [7:0] b,
                                             logic [7:0] ix);
    line_result_t r;
    int eff;
    int p;
    r = '0;
    if (op == atcmd_pkg::OP_READ) begin
      r.read_data = line_mem[ix];
      return r;
    end
    r.echo_valid = 1'b1;
    r.echo_byte  = b;
    if (b == atcmd_pkg::CH_CR || b == atcmd_pkg::CH_LF) begin
      if (line_len == 0) return r;
      eff = line_len;
      if (zero_at >= 0 && zero_at < eff) eff = zero_at;
      r.line_done = 1'b1;
      if (eff == 0) r.cmd_code = atcmd_pkg::CMD_EMPTY;
      else if (head_is("AT", eff, 1)) r.cmd_code = atcmd_pkg::CMD_AT;
      else if (head_is("AT+HELP", eff, 1) || head_is("AT+HELP?", eff, 1)) begin
        r.cmd_code = atcmd_pkg::CMD_USAGE;
      end
      else if (head_is("AT+WEATHER?", eff, 1)) r.cmd_code = atcmd_pkg::CMD_FORECAST;
      else if (head_is("AT+TEMP?", eff, 1)) r.cmd_code = atcmd_pkg::CMD_THERMAL;
      else if (head_is("AT+LUX?", eff, 1)) r.cmd_code = atcmd_pkg::CMD_LUX;
      else if (head_is("AT+BAT?", eff, 1)) r.cmd_code = atcmd_pkg::CMD_BAT;
      else if (head_is("AT+RST", eff, 1)) r.cmd_code = atcmd_pkg::CMD_RST;
      else if (head_is("AT+WIFI=", eff, 0)) begin
        if (eff == 8) r.cmd_code = atcmd_pkg::CMD_WIFI_NARG;
        else if (comma_at < 0 || comma_at >= eff) r.cmd_code = atcmd_pkg::CMD_WIFI_NCOM;
        else begin
          r.cmd_code    = atcmd_pkg::CMD_WIFI_OK;
          r.comma_index = 8'(comma_at);
          r.name_len    = clip_len(comma_at - 8);
          r.pwd_len     = clip_len(eff - comma_at - 1);
        end
      end else r.cmd_code = atcmd_pkg::CMD_UNKNOWN;
      line_len = 0;
      comma_at = -1;
      zero_at  = -1;
    end else if (b == atcmd_pkg::CH_BS || b == atcmd_pkg::CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
        if (zero_at == line_len) zero_at = -1;
        if (comma_at == line_len) comma_at = -1;
      end
    end else if (line_len < int'(atcmd_pkg::LINE_CAP) - 2) begin
      p = line_len;
      line_mem[p]     = b;
      line_mem_set[p] = 1'b1;
      if (p < atcmd_pkg::PREFIX_LEN) head_chars[p] = b;
      if (b == atcmd_pkg::CH_NUL && zero_at < 0) zero_at = p;
      if (b == atcmd_pkg::CH_COMMA && comma_at < 0) comma_at = p;
      line_len = p + 1;
    end
    return r;
  endfunction

  // only positions written since reset are ever read back
  function automatic logic [7:0] pick_written();
    int s;
    int j;
    s = $urandom_range(0, atcmd_pkg::LINE_CAP - 3);
    for (int k = 0; k < int'(atcmd_pkg::LINE_CAP) - 2; k++) begin
      j = (s + k) % (int'(atcmd_pkg::LINE_CAP) - 2);
      if (line_mem_set[j]) return 8'(j);
    end
    return 8'h00;
  endfunction

  function automatic string show(line_result_t r);
    return $sformatf("echo %0b/%02h done %0b cmd %0d comma %0d name %0d pwd %0d data %02h",
                     r.echo_valid, r.echo_byte, r.line_done, r.cmd_code, r.comma_index,
                     r.name_len, r.pwd_len, r.read_data);
  endfunction

  function automatic dir_row_t rx_chk(logic [7:0] b, logic ld, atcmd_pkg::cmd_code_e code);
    dir_row_t t;
    t.op  = atcmd_pkg::OP_RX;
    t.rx  = b;
    t.ix  = 8'h00;
    t.typed = 1'b1;
    t.res = '0;
    t.res.echo_valid = 1'b1;
    t.res.echo_byte  = b;
    t.res.line_done  = ld;
    t.res.cmd_code   = code;
    return t;
  endfunction

  function automatic dir_row_t rx_row(logic [7:0] b);
    dir_row_t t;
    t = rx_chk(b, 1'b0, atcmd_pkg::CMD_EMPTY);
    t.typed = 1'b0;
    return t;
  endfunction

  function automatic dir_row_t rd_chk(logic [7:0] ix, logic [7:0] d);
    dir_row_t t;
    t.op  = atcmd_pkg::OP_READ;
    t.rx  = 8'h00;
    t.ix  = ix;
    t.typed = 1'b1;
    t.res = '0;
    t.res.read_data = d;
    return t;
  endfunction

  function automatic logic [7:0] text_char(bit commas);
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (!commas && c == atcmd_pkg::CH_COMMA);
    return c;
  endfunction

  function automatic int field_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(120, 170);
    if (r < 18) return $urandom_range(58, 72);
    return $urandom_range(0, 12);
  endfunction

  task automatic drive(input atcmd_pkg::op_e op, input logic [7:0] b, input logic [7:0] ix,
                       input bit pick, input bit typed, input line_result_t gold);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    command_i    <= op;
    rx_byte_i    <= b;
    read_index_i <= pick ? pick_written() : ix;
    gold_on      <= typed;
    gold_res     <= gold;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive(atcmd_pkg::OP_RX, b, 8'($urandom_range(0, 253)), 1'b0, 1'b0, '0);
  endtask

  task automatic send_read();
    drive(atcmd_pkg::OP_READ, 8'($urandom_range(0, 255)), 8'h00, 1'b1, 1'b0, '0);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic end_line();
    send_byte($urandom_range(0, 1) ? atcmd_pkg::CH_CR : atcmd_pkg::CH_LF);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_sequence(input seq_kind_e kind);
    string s;
    int n;
    int v;
    int cut;
    int spot;
    case (kind)
      SEQ_KNOWN: begin
        s = known_cmds[$urandom_range(0, 7)];
        v = $urandom_range(0, 99);
        cut = (v < 10) ? s.len() - 1 : s.len();
        spot = $urandom_range(0, cut);
        for (int k = 0; k < cut; k++) begin
          if (v >= 80 && k == spot) begin
            send_byte(text_char(1'b1));
            send_byte($urandom_range(0, 1) ? atcmd_pkg::CH_BS : atcmd_pkg::CH_DEL);
          end
          send_byte(s[k]);
        end
        if (v >= 10 && v < 20) send_byte(text_char(1'b1));
        end_line();
      end
      SEQ_WIFI: begin
        send_text("AT+WIFI=");
        n = field_len();
        repeat (n) begin
          send_byte(($urandom_range(0, 49) == 0) ? atcmd_pkg::CH_NUL : text_char(1'b0));
        end
        if ($urandom_range(0, 99) < 85) begin
          send_byte(atcmd_pkg::CH_COMMA);
          n = field_len();
          repeat (n) send_byte(text_char(1'b1));
        end
        if ($urandom_range(0, 9) == 0) send_byte(atcmd_pkg::CH_BS);
        end_line();
      end
      SEQ_READS: begin
        repeat ($urandom_range(1, 3)) send_read();
      end
      SEQ_NOISE: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) send_read();
          else send_byte(8'($urandom_range(0, 255)));
        end
      end
      SEQ_JUNK: begin
        if ($urandom_range(0, 1)) send_text("AT+");
        n = $urandom_range(1, 20);
        repeat (n) send_byte(text_char(1'b1));
        end_line();
      end
      SEQ_LONG: begin
        // usually overruns the line store
        if ($urandom_range(0, 1)) send_text("AT+WIFI=");
        n = $urandom_range(250, 270);
        repeat (n) send_byte(text_char($urandom_range(0, 3) == 0));
        end_line();
        repeat (2) send_read();
      end
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    line_result_t want;
    line_result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.echo_valid  = echo_valid_o;
        got.echo_byte   = echo_byte_o;
        got.line_done   = line_done_o;
        got.cmd_code    = atcmd_pkg::cmd_code_e'(cmd_code_o);
        got.comma_index = comma_index_o;
        got.name_len    = name_len_o;
        got.pwd_len     = pwd_len_o;
        got.read_data   = read_data_o;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result %0d with no request pending: %s",
                                         results_seen, show(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d expected %s", results_seen, show(want));
              $display("result %0d actual   %s", results_seen, show(got));
            end
          end
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        want = recognize(atcmd_pkg::op_e'(command_i), rx_byte_i, read_index_i);
        if (gold_on) want = gold_res;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("at_command_line_recognizer_core: mismatch");
      $finish;
    end
  end

  initial begin
    string wifi_txt;
    int r;
    seq_kind_e kind;
    wifi_txt = "AT+WIFI=";
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_CR, 1'b0, atcmd_pkg::CMD_EMPTY));
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_BS, 1'b0, atcmd_pkg::CMD_EMPTY));
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_DEL, 1'b0, atcmd_pkg::CMD_EMPTY));
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_LF, 1'b0, atcmd_pkg::CMD_EMPTY));
    dir_tab.push_back(rx_row("A"));
    dir_tab.push_back(rx_row("T"));
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_CR, 1'b1, atcmd_pkg::CMD_AT));
    // line that starts with a zero byte
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_NUL, 1'b0, atcmd_pkg::CMD_EMPTY));
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_LF, 1'b1, atcmd_pkg::CMD_EMPTY));
    for (int k = 0; k < 8; k++) dir_tab.push_back(rx_row(wifi_txt[k]));
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_CR, 1'b1, atcmd_pkg::CMD_WIFI_NARG));
    dir_tab.push_back(rd_chk(8'd0, "A"));
    dir_tab.push_back(rd_chk(8'd7, "="));
    dir_tab.push_back(rx_chk(8'hFF, 1'b0, atcmd_pkg::CMD_EMPTY));
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_DEL, 1'b0, atcmd_pkg::CMD_EMPTY));
    dir_tab.push_back(rx_chk(8'hFF, 1'b0, atcmd_pkg::CMD_EMPTY));
    dir_tab.push_back(rx_chk(atcmd_pkg::CH_LF, 1'b1, atcmd_pkg::CMD_UNKNOWN));
    dir_tab.push_back(rd_chk(8'd0, 8'hFF));

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      drive(dir_tab[k].op, dir_tab[k].rx, dir_tab[k].ix, 1'b0, dir_tab[k].typed,
            dir_tab[k].res);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_pct_by_phase[ph];
      rx_stall_pct = rx_pct_by_phase[ph];
      if (ph == 0) send_sequence(SEQ_LONG);
      // long receiver hold while requests keep coming
      if (ph == 1) hold_asks++;
      while (items_sent < dir_tab.size() + (ph + 1) * PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 33) kind = SEQ_KNOWN;
        else if (r < 58) kind = SEQ_WIFI;
        else if (r < 70) kind = SEQ_READS;
        else if (r < 85) kind = SEQ_NOISE;
        else if (r < 99) kind = SEQ_JUNK;
        else kind = SEQ_LONG;
        send_sequence(kind);
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("at_command_line_recognizer_core: match");
    end else begin
      $display("at_command_line_recognizer_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/atcmd_pkg.sv
rtl/atcmd_ram.sv
rtl/atcmd_line_track.sv
rtl/atcmd_classify.sv
rtl/at_command_line_recognizer_core.sv
tb/at_command_line_recognizer_core_test.sv
